// ----- sv/rtt_pkg.sv -----
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types and constants for the RGB555 tone and tint block.
// ----------------------------------------------------------------------------
package rtt_pkg;

	localparam int unsigned CHAN_W   = 5;
	localparam int unsigned COLOR_W  = 3 * CHAN_W;
	localparam int unsigned GAIN_W   = 11;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 5'h1F;

	localparam logic [7:0] LUMA_R_COEF = 8'd76;
	localparam logic [7:0] LUMA_G_COEF = 8'd151;
	localparam logic [7:0] LUMA_B_COEF = 8'd29;

	localparam logic [GAIN_W-1:0] SEPIA_R_GAIN = 11'd307;
	localparam logic [GAIN_W-1:0] SEPIA_G_GAIN = 11'd256;
	localparam logic [GAIN_W-1:0] SEPIA_B_GAIN = 11'd240;
	localparam logic [GAIN_W-1:0] GAIN_RESET   = 11'd256;

	typedef enum logic [1:0] {
		MODE_GRAY    = 2'd0,
		MODE_ROUNDED = 2'd1,
		MODE_SEPIA   = 2'd2,
		MODE_CUSTOM  = 2'd3
	} tint_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TINT_MODE  = 2'd0,
		REG_RED_GAIN   = 2'd1,
		REG_GREEN_GAIN = 2'd2,
		REG_BLUE_GAIN  = 2'd3
	} cfg_reg_t;

	localparam logic [CHAN_W-1:0] STEP_TABLE [32] = '{
		5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
		5'd5,  5'd5,  5'd5,  5'd5,  5'd5,
		5'd11, 5'd11, 5'd11, 5'd11, 5'd11,
		5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
		5'd21, 5'd21, 5'd21, 5'd21, 5'd21,
		5'd27, 5'd27, 5'd27, 5'd27, 5'd27,
		5'd31, 5'd31
	};

endpackage

// ----- sv/rgb555_tone_tint.sv -----
// ----------------------------------------------------------------------------
// rgb555_tone_tint
// Grayscale, rounded grayscale, sepia and custom tone tint of RGB555 colors.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive color_in and last_in with start high; the item is taken at
//   that clock edge. busy is always low, so one item can enter every cycle.
//   Output: done pulses for one cycle with color_out and last_out valid. The
//   receiver cannot stall, so the pipeline never holds.
//   Pipeline: four register stages (luma products, luma sum, tone products,
//   saturate and pack); throughput one item per cycle.
//   Configuration: cfg_we writes cfg_data to register cfg_index (0 mode,
//   1 red gain, 2 green gain, 3 blue gain). Write only while no item is in
//   flight; the registers are read live by the later stages.
//   Reset: arst_n clears the pipeline valid bits, sets mode to grayscale
//   and all gains to 1.0 (256 in Q3.8). Items in flight are dropped.
// ----------------------------------------------------------------------------
module rgb555_tone_tint (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [rtt_pkg::COLOR_W-1:0]           color_in,
	input  logic                                  last_in,
	output logic                                  done,
	output logic [rtt_pkg::COLOR_W-1:0]           color_out,
	output logic                                  last_out,
	input  logic                                  cfg_we,
	input  logic [rtt_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [rtt_pkg::GAIN_W-1:0]            cfg_data
);
	import rtt_pkg::*;

	tint_mode_t          mode_q;
	logic [GAIN_W-1:0]   red_gain_q;
	logic [GAIN_W-1:0]   green_gain_q;
	logic [GAIN_W-1:0]   blue_gain_q;

	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	logic                last_s1, last_s2, last_s3, last_s4;
	logic [11:0]         prod_r_s1;
	logic [12:0]         prod_g_s1;
	logic [9:0]          prod_b_s1;
	logic [CHAN_W-1:0]   luma_s2;
	logic [15:0]         tone_r_s3, tone_g_s3, tone_b_s3;
	logic [CHAN_W-1:0]   gray_s3;
	logic                use_gray_s3;
	logic [COLOR_W-1:0]  color_s4;

	logic                accept;
	logic [12:0]         luma_sum;
	logic [GAIN_W-1:0]   gain_r, gain_g, gain_b;
	logic [CHAN_W-1:0]   chan_r, chan_g, chan_b;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_GRAY;
			red_gain_q   <= GAIN_RESET;
			green_gain_q <= GAIN_RESET;
			blue_gain_q  <= GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TINT_MODE:  mode_q       <= tint_mode_t'(cfg_data[1:0]);
				REG_RED_GAIN:   red_gain_q   <= cfg_data;
				REG_GREEN_GAIN: green_gain_q <= cfg_data;
				REG_BLUE_GAIN:  blue_gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage 1: luma products
	always_ff @(posedge clk) begin
		prod_r_s1 <= 12'(color_in[4:0]   * LUMA_R_COEF);
		prod_g_s1 <= 13'(color_in[9:5]   * LUMA_G_COEF);
		prod_b_s1 <= 10'(color_in[14:10] * LUMA_B_COEF);
		last_s1   <= last_in;
	end

	// stage 2: luma sum, never above 31
	assign luma_sum = 13'(prod_r_s1) + prod_g_s1 + 13'(prod_b_s1);

	always_ff @(posedge clk) begin
		luma_s2 <= luma_sum[12:8];
		last_s2 <= last_s1;
	end

	// stage 3: tone products or gray value
	always_comb begin
		if (mode_q == MODE_SEPIA) begin
			gain_r = SEPIA_R_GAIN;
			gain_g = SEPIA_G_GAIN;
			gain_b = SEPIA_B_GAIN;
		end else begin
			gain_r = red_gain_q;
			gain_g = green_gain_q;
			gain_b = blue_gain_q;
		end
	end

	always_ff @(posedge clk) begin
		tone_r_s3   <= 16'(gain_r * luma_s2);
		tone_g_s3   <= 16'(gain_g * luma_s2);
		tone_b_s3   <= 16'(gain_b * luma_s2);
		gray_s3     <= (mode_q == MODE_ROUNDED) ? STEP_TABLE[luma_s2] : luma_s2;
		use_gray_s3 <= (mode_q == MODE_GRAY) || (mode_q == MODE_ROUNDED);
		last_s3     <= last_s2;
	end

	// stage 4: shift, saturate, pack
	assign chan_r = (tone_r_s3[15:13] != 3'd0) ? CHAN_MAX : tone_r_s3[12:8];
	assign chan_g = (tone_g_s3[15:13] != 3'd0) ? CHAN_MAX : tone_g_s3[12:8];
	assign chan_b = (tone_b_s3[15:13] != 3'd0) ? CHAN_MAX : tone_b_s3[12:8];

	always_ff @(posedge clk) begin
		if (use_gray_s3) begin
			color_s4 <= {gray_s3, gray_s3, gray_s3};
		end else begin
			color_s4 <= {chan_b, chan_g, chan_r};
		end
		last_s4 <= last_s3;
	end

	assign done      = valid_s4;
	assign color_out = color_s4;
	assign last_out  = last_s4;

endmodule

// ----- tb/tb_rgb555_tone_tint.sv -----
// ----------------------------------------------------------------------------
// tb_rgb555_tone_tint
// Self-checking bench for the RGB555 tone and tint block. A small checker
// class predicts the tinted color of every accepted item from its own copy
// of the tint registers and matches each done pulse against the oldest
// prediction. The stimulus covers directed corner colors in all four modes,
// then random phases under random register settings, with random gaps on
// the sending side.
// ----------------------------------------------------------------------------
module tb_rgb555_tone_tint;
	import rtt_pkg::*;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               last;
	} tinted_t;

	class tint_checker;
		tint_mode_t        mode;
		logic [GAIN_W-1:0] red_gain;
		logic [GAIN_W-1:0] green_gain;
		logic [GAIN_W-1:0] blue_gain;
		tinted_t           pending_tints[$];
		int                errors;

		function new();
			mode = MODE_GRAY;
			red_gain = 11'd256;
			green_gain = 11'd256;
			blue_gain = 11'd256;
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [GAIN_W-1:0] data);
			case (idx)
				REG_TINT_MODE:  mode = tint_mode_t'(data[1:0]);
				REG_RED_GAIN:   red_gain = data;
				REG_GREEN_GAIN: green_gain = data;
				REG_BLUE_GAIN:  blue_gain = data;
			endcase
		endfunction

		function logic [4:0] scale_chan(logic [GAIN_W-1:0] gain, logic [4:0] luma);
			int unsigned prod;
			prod = (int'(gain) * int'(luma)) >> 8;
			return (prod > 31) ? 5'd31 : prod[4:0];
		endfunction

		function logic [4:0] round_luma(logic [4:0] luma);
			case (luma / 5)
				0: return 5'd0;
				1: return 5'd5;
				2: return 5'd11;
				3: return 5'd16;
				4: return 5'd21;
				5: return 5'd27;
				default: return 5'd31;
			endcase
		endfunction

		function logic [COLOR_W-1:0] tint_color(logic [COLOR_W-1:0] c);
			int unsigned sum;
			logic [4:0] luma;
			logic [4:0] ro, go, bo;
			sum = 76 * int'(c[4:0]) + 151 * int'(c[9:5]) + 29 * int'(c[14:10]);
			sum = sum >> 8;
			luma = (sum > 31) ? 5'd31 : sum[4:0];
			case (mode)
				MODE_GRAY: begin
					ro = luma; go = luma; bo = luma;
				end
				MODE_ROUNDED: begin
					ro = round_luma(luma); go = ro; bo = ro;
				end
				MODE_SEPIA: begin
					ro = scale_chan(11'd307, luma);
					go = scale_chan(11'd256, luma);
					bo = scale_chan(11'd240, luma);
				end
				default: begin
					ro = scale_chan(red_gain, luma);
					go = scale_chan(green_gain, luma);
					bo = scale_chan(blue_gain, luma);
				end
			endcase
			return {bo, go, ro};
		endfunction

		function void note_item(logic [COLOR_W-1:0] c, logic l);
			tinted_t t;
			t.color = tint_color(c);
			t.last = l;
			pending_tints.push_back(t);
		endfunction

		function int pending();
			return pending_tints.size();
		endfunction

		task report_mismatch(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [COLOR_W-1:0] c, logic l);
			tinted_t t;
			if (pending_tints.size() == 0) begin
				report_mismatch($sformatf("unexpected result color=%h last=%b", c, l));
				return;
			end
			t = pending_tints.pop_front();
			if (c !== t.color)
				report_mismatch($sformatf("color_out %h, predicted %h", c, t.color));
			if (l !== t.last)
				report_mismatch($sformatf("last_out %b, predicted %b", l, t.last));
		endtask
	endclass

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [COLOR_W-1:0] color_in = '0;
	logic               last_in = 1'b0;
	logic               done;
	logic [COLOR_W-1:0] color_out;
	logic               last_out;
	logic               cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0]  cfg_data = '0;

	tint_checker sb;
	int          sent;
	bit          burst;

	rgb555_tone_tint dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.color_in  (color_in),
		.last_in   (last_in),
		.done      (done),
		.color_out (color_out),
		.last_out  (last_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(color_out, last_out);
	end

	function automatic int pick_gap();
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return '0;
		if (r < 50)
			return 11'd2047;
		if (r < 60)
			return 11'd256;
		return GAIN_W'($urandom_range(0, 2047));
	endfunction

	function automatic logic [4:0] pick_chan();
		case ($urandom_range(0, 2))
			0: return 5'd0;
			1: return 5'd31;
			default: return 5'($urandom_range(0, 31));
		endcase
	endfunction

	function automatic logic [COLOR_W-1:0] pick_color();
		if ($urandom_range(0, 9) < 7)
			return COLOR_W'($urandom_range(0, 32767));
		return {pick_chan(), pick_chan(), pick_chan()};
	endfunction

	// call at a rising edge; returns at the edge that takes the item
	task automatic send_color(logic [COLOR_W-1:0] c, logic l);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		color_in <= c;
		last_in <= l;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		sb.note_item(c, l);
		sent++;
	endtask

	task automatic drain(int settle);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [GAIN_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic apply_config(tint_mode_t m, logic [GAIN_W-1:0] rg,
			logic [GAIN_W-1:0] gg, logic [GAIN_W-1:0] bg);
		logic [GAIN_W-3:0] junk;
		junk = $urandom_range(0, 1) ? (GAIN_W-2)'($urandom_range(0, 511)) : '0;
		cfg_write(REG_RED_GAIN, rg);
		cfg_write(REG_TINT_MODE, {junk, m});
		cfg_write(REG_GREEN_GAIN, gg);
		cfg_write(REG_BLUE_GAIN, bg);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		logic [COLOR_W-1:0] corners[6];
		int phase_len;
		int last_run;
		tint_mode_t m;
		sb = new();
		sent = 0;
		burst = 1'b0;
		corners = '{15'h0000, 15'h7FFF, 15'h001F, 15'h03E0, 15'h7C00, 15'h14A5};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < 4; k++) begin
			if (k > 0) begin
				drain(6);
				apply_config(tint_mode_t'(k), 11'd2047, 11'd0, 11'd256);
			end
			foreach (corners[i])
				send_color(corners[i], i[0]);
		end

		while (sent < 910) begin
			drain(6);
			m = ($urandom_range(0, 4) < 2) ? MODE_CUSTOM : tint_mode_t'($urandom_range(0, 3));
			apply_config(m, pick_gain(), pick_gain(), pick_gain());
			burst = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(1, 80);
			last_run = $urandom_range(1, 16);
			for (int i = 0; i < phase_len; i++)
				send_color(pick_color(), (i % last_run) == last_run - 1);
		end

		drain(10);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
